// ===== hdl/ob_pkg.sv =====
// shared types and constants for the order book
`default_nettype none
package ob_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;

    typedef struct packed {
        logic start;   // clear scan state, begin sweep
        logic step;    // process one slot
        logic commit;  // apply write or free, capture result
    } ob_cmd_t;

    typedef struct packed {
        logic last;    // sweep reached final slot
    } ob_stat_t;
endpackage
`default_nettype wire

// ===== hdl/ob_ctrl.sv =====
// controller: sequences the slot sweep and the output handshake
`default_nettype none
module ob_ctrl
    import ob_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output ob_cmd_t   cmd,
    input  ob_stat_t  stat
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_OUT} state_t;
    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = m_valid_reg;
    assign cmd.start  = s_valid && s_ready;
    assign cmd.step   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_COMMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:   if (s_valid) state_reg <= S_SCAN;
                S_SCAN:   if (stat.last) state_reg <= S_COMMIT;
                S_COMMIT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_OUT;
                end
                S_OUT:    if (m_ready) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ob_dp.sv =====
// datapath: slot table, one-slot-per-cycle search and top-of-book scan
`default_nettype none
module ob_dp
    import ob_pkg::*;
#(
    parameter int BOOK_SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_op,
    input  wire logic [31:0] s_price,
    input  wire logic        s_side,
    input  wire logic [31:0] s_cancel_id,
    input  ob_cmd_t          cmd,
    output ob_stat_t         stat,
    output logic [1:0]       m_status,
    output logic [31:0]      m_new_id,
    output logic             m_bid_valid,
    output logic [31:0]      m_best_bid,
    output logic             m_ask_valid,
    output logic [31:0]      m_best_ask
);
    localparam int IW = (BOOK_SLOTS > 1) ? $clog2(BOOK_SLOTS) : 1;

    logic [BOOK_SLOTS-1:0] live_reg;
    logic [31:0] id_mem [BOOK_SLOTS];
    logic [31:0] pr_mem [BOOK_SLOTS];
    logic        sd_mem [BOOK_SLOTS];

    logic [31:0] next_id_reg;
    logic        op_reg, side_reg;
    logic [31:0] price_reg, cid_reg;
    logic [IW-1:0] idx_reg;
    logic        found_reg;
    logic [IW-1:0] hit_reg;
    logic        bv_reg, av_reg;
    logic [31:0] bb_reg, ba_reg;
    logic [1:0]  status_reg;
    logic [31:0] new_id_reg, obb_reg, oba_reg;
    logic        obv_reg, oav_reg;

    // table read one slot ahead of the sweep index
    logic [IW-1:0] rd_addr;
    logic [31:0]   id_rd_reg, pr_rd_reg;
    logic          sd_rd_reg;

    // effective liveness: pending add counts as live, pending cancel as dead
    logic        slot_live, slot_side, match, is_hit;
    logic [31:0] slot_price;
    logic        add_here;

    assign stat.last  = (idx_reg == IW'(BOOK_SLOTS - 1));
    assign rd_addr    = (cmd.step && !stat.last) ? idx_reg + 1'b1 : '0;
    assign add_here   = (op_reg == OP_ADD) && !live_reg[idx_reg] && !found_reg;
    assign match      = (op_reg == OP_CANCEL) && live_reg[idx_reg] && !found_reg
                        && (id_rd_reg == cid_reg);
    assign is_hit     = add_here || match;
    assign slot_live  = add_here ? 1'b1 : (match ? 1'b0 : live_reg[idx_reg]);
    assign slot_side  = add_here ? side_reg : sd_rd_reg;
    assign slot_price = add_here ? price_reg : pr_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            next_id_reg <= '0;
        end else begin
            if (cfg_we) next_id_reg <= cfg_wdata;
            if (cmd.start) begin
                op_reg    <= s_op;
                side_reg  <= s_side;
                price_reg <= s_price;
                cid_reg   <= s_cancel_id;
                idx_reg   <= '0;
                found_reg <= 1'b0;
                bv_reg    <= 1'b0;
                av_reg    <= 1'b0;
                bb_reg    <= '0;
                ba_reg    <= '0;
            end
            if (cmd.step) begin
                if (is_hit) begin
                    found_reg <= 1'b1;
                    hit_reg   <= idx_reg;
                end
                if (slot_live) begin
                    if (!slot_side) begin
                        if (!bv_reg || slot_price > bb_reg) begin
                            bb_reg <= slot_price;
                            bv_reg <= 1'b1;
                        end
                    end else if (!av_reg || slot_price < ba_reg) begin
                        ba_reg <= slot_price;
                        av_reg <= 1'b1;
                    end
                end
                if (!stat.last) idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.commit) begin
                obv_reg <= bv_reg;
                obb_reg <= bb_reg;
                oav_reg <= av_reg;
                oba_reg <= ba_reg;
                if (op_reg == OP_ADD) begin
                    if (found_reg) begin
                        live_reg[hit_reg] <= 1'b1;
                        new_id_reg        <= next_id_reg;
                        next_id_reg       <= next_id_reg + 32'd1;
                        status_reg        <= ST_OK;
                    end else begin
                        new_id_reg <= '0;
                        status_reg <= ST_FULL;
                    end
                end else begin
                    new_id_reg <= '0;
                    if (found_reg) begin
                        live_reg[hit_reg] <= 1'b0;
                        status_reg        <= ST_OK;
                    end else begin
                        status_reg <= ST_UNKNOWN;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && op_reg == OP_ADD && found_reg) begin
            id_mem[hit_reg] <= next_id_reg;
            pr_mem[hit_reg] <= price_reg;
            sd_mem[hit_reg] <= side_reg;
        end
        id_rd_reg <= id_mem[rd_addr];
        pr_rd_reg <= pr_mem[rd_addr];
        sd_rd_reg <= sd_mem[rd_addr];
    end

    assign m_status    = status_reg;
    assign m_new_id    = new_id_reg;
    assign m_bid_valid = obv_reg;
    assign m_best_bid  = obb_reg;
    assign m_ask_valid = oav_reg;
    assign m_best_ask  = oba_reg;
endmodule
`default_nettype wire

// ===== hdl/limit_order_book_top.sv =====
// the table is swept one slot per cycle between accepting an order and raising result valid
// a new order is accepted only after the previous result has been taken at the output
// the sweep finds the free slot or cancel match and the best bid and ask together
// synchronous active-low reset empties the book and loads next id with zero
`default_nettype none
module limit_order_book_top
    import ob_pkg::*;
#(
    parameter int BOOK_SLOTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [31:0] s_price,
    input  wire logic        s_side,
    input  wire logic [31:0] s_cancel_id,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_new_id,
    output logic             m_bid_valid,
    output logic [31:0]      m_best_bid,
    output logic             m_ask_valid,
    output logic [31:0]      m_best_ask
);
    ob_cmd_t  cmd;
    ob_stat_t stat;

    ob_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .cmd, .stat
    );

    ob_dp #(.BOOK_SLOTS(BOOK_SLOTS)) u_dp (
        .aclk, .aresetn, .cfg_we, .cfg_wdata, .s_op, .s_price, .s_side, .s_cancel_id,
        .cmd, .stat, .m_status, .m_new_id, .m_bid_valid, .m_best_bid,
        .m_ask_valid, .m_best_ask
    );
endmodule
`default_nettype wire

// ===== bench/limit_order_book_top_tb.sv =====
// self-checking bench for the order book: directed and random adds and cancels against a predictor
`default_nettype none
module limit_order_book_top_tb;
    import ob_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int LIMIT_CYCLES = 3_000_000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_id;
        logic        bid_valid;
        logic [31:0] best_bid;
        logic        ask_valid;
        logic [31:0] best_ask;
    } book_top_t;

    class book_scoreboard;
        bit          live[DEPTH];
        logic [31:0] oid[DEPTH];
        logic [31:0] px[DEPTH];
        logic        sd[DEPTH];
        logic [31:0] next_order_id;
        book_top_t   pending[$];
        int          errors;

        function void clear_book(logic [31:0] first);
            foreach (live[i]) live[i] = 0;
            next_order_id = first;
        endfunction

        // count of live entries in the predictor, used to steer the stimulus
        function int live_count();
            int n;
            n = 0;
            foreach (live[i]) n += live[i];
            return n;
        endfunction

        function logic [31:0] some_live_id();
            int idx[$];
            foreach (live[i]) if (live[i]) idx.push_back(i);
            if (idx.size() == 0) return $urandom;
            return oid[idx[$urandom_range(0, idx.size() - 1)]];
        endfunction

        function void note_order(logic op, logic [31:0] price, logic side, logic [31:0] cid);
            book_top_t r;
            int hit;
            r = '0;
            r.status = ST_OK;
            hit = -1;
            if (op == OP_ADD) begin
                foreach (live[i]) if (!live[i] && hit < 0) hit = i;
                if (hit < 0) r.status = ST_FULL;
                else begin
                    r.new_id = next_order_id;
                    next_order_id++;
                    live[hit] = 1; oid[hit] = r.new_id; px[hit] = price; sd[hit] = side;
                end
            end else begin
                foreach (live[i]) if (live[i] && oid[i] == cid && hit < 0) hit = i;
                if (hit < 0) r.status = ST_UNKNOWN;
                else live[hit] = 0;
            end
            foreach (live[i]) begin
                if (live[i] && sd[i] == 1'b0 && (!r.bid_valid || px[i] > r.best_bid)) begin
                    r.bid_valid = 1; r.best_bid = px[i];
                end
                if (live[i] && sd[i] == 1'b1 && (!r.ask_valid || px[i] < r.best_ask)) begin
                    r.ask_valid = 1; r.best_ask = px[i];
                end
            end
            pending.push_back(r);
        endfunction

        function void check_top(book_top_t got);
            book_top_t e;
            if (pending.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.new_id !== e.new_id) begin
                $error("new_id exp %0h got %0h", e.new_id, got.new_id); errors++;
            end
            if (got.bid_valid !== e.bid_valid) begin
                $error("bid_valid exp %0d got %0d", e.bid_valid, got.bid_valid); errors++;
            end
            if (got.best_bid !== e.best_bid) begin
                $error("best_bid exp %0h got %0h", e.best_bid, got.best_bid); errors++;
            end
            if (got.ask_valid !== e.ask_valid) begin
                $error("ask_valid exp %0d got %0d", e.ask_valid, got.ask_valid); errors++;
            end
            if (got.best_ask !== e.best_ask) begin
                $error("best_ask exp %0h got %0h", e.best_ask, got.best_ask); errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 0;
    logic        s_ready;
    logic        s_op = OP_ADD;
    logic [31:0] s_price = '0;
    logic        s_side = 0;
    logic [31:0] s_cancel_id = '0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [1:0]  m_status;
    logic [31:0] m_new_id, m_best_bid, m_best_ask;
    logic        m_bid_valid, m_ask_valid;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;
    book_scoreboard sb;

    always #5 aclk = ~aclk;

    limit_order_book_top #(.BOOK_SLOTS(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_price(s_price),
        .s_side(s_side), .s_cancel_id(s_cancel_id),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_new_id(m_new_id),
        .m_bid_valid(m_bid_valid), .m_best_bid(m_best_bid),
        .m_ask_valid(m_ask_valid), .m_best_ask(m_best_ask)
    );

    // receiver side: random stall, check at each accepted result
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready)
            sb.check_top({m_status, m_new_id, m_bid_valid, m_best_bid,
                          m_ask_valid, m_best_ask});
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (cycles > LIMIT_CYCLES) begin
            $display("limit_order_book_top: mismatch");
            $finish;
        end
    end

    // valid stays up across back-to-back items, drops only in idle cycles
    task automatic send_order(logic op, logic [31:0] price, logic side, logic [31:0] cid);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_op <= op; s_price <= price; s_side <= side; s_cancel_id <= cid;
        sb.note_order(op, price, side, cid);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_first_id(logic [31:0] v);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        cfg_we <= 1; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.next_order_id = v;
    endtask

    task automatic random_orders(int n);
        int k;
        logic [31:0] p;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: p = $urandom;
                1: p = $urandom_range(0, 15);
                2: p = 32'hFFFF_FFFF - $urandom_range(0, 15);
                default: p = $urandom_range(1000, 1040);
            endcase
            // bias toward adds while the book is shallow, cancels of live ids otherwise
            if ($urandom_range(0, 99) < (sb.live_count() < 40 ? 65 : 35))
                send_order(OP_ADD, p, 1'($urandom_range(0, 1)), $urandom);
            else if ($urandom_range(0, 9) == 0)
                send_order(OP_CANCEL, p, 1'($urandom_range(0, 1)), $urandom);
            else
                send_order(OP_CANCEL, p, 1'($urandom_range(0, 1)), sb.some_live_id());
        end
    endtask

    initial begin
        int k;
        sb = new();
        sb.clear_book(32'd0);
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty-book cancel, extremes, fill to exhaustion, eight cancels of live ids
        send_order(OP_CANCEL, 32'd0, 1'b0, 32'd0);
        send_order(OP_ADD, 32'd0, 1'b0, 32'hFFFF_FFFF);
        send_order(OP_ADD, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send_order(OP_ADD, 32'hFFFF_FFFF, 1'b0, 32'd0);
        send_order(OP_ADD, 32'd0, 1'b1, 32'd0);
        send_order(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 32'd2);
        send_order(OP_CANCEL, 32'd0, 1'b0, 32'd2);
        send_order(OP_CANCEL, 32'd0, 1'b0, 32'hFFFF_FFFF);
        for (k = 0; k < DEPTH + 2; k++)
            send_order(OP_ADD, $urandom, k[0], $urandom);
        for (k = 0; k < 8; k++)
            send_order(OP_CANCEL, $urandom, 1'b0, sb.some_live_id());
        random_orders(20);

        // id wrap, duplicates after wrap, receiver stalls and sender idles
        write_first_id(32'hFFFF_FFFE);
        random_orders(250);
        write_first_id(32'hFFFF_FFFF);
        recv_stall_pct = 88;
        random_orders(250);
        write_first_id($urandom);
        recv_stall_pct = 0; send_idle_pct = 88;
        random_orders(250);
        write_first_id(32'd0);
        recv_stall_pct = 8; send_idle_pct = 8;
        random_orders(200);

        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        if (sb.errors == 0)
            $display("limit_order_book_top: match");
        else
            $display("limit_order_book_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
